@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the decimal digit display framer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define DDF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check on every clock edge, reset included
`define DDF_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/ddf_pkg.sv @@
// ----------------------------------------------------------------------------
// ddf_pkg
// Types and constants of the decimal digit display framer.
// ----------------------------------------------------------------------------
package ddf_pkg;

	localparam int MAX_DIGITS  = 8;
	localparam int VALUE_W     = 31;
	localparam int DIGIT_W     = 4;
	localparam int COUNT_W     = 4;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 8;
	localparam int BITCNT_W    = $clog2(VALUE_W);
	localparam int INIT_FRAMES = 5;

	localparam logic [ADDR_W-1:0] ADDR_DECODE    = 4'h9;
	localparam logic [ADDR_W-1:0] ADDR_TEST      = 4'hF;
	localparam logic [ADDR_W-1:0] ADDR_SCAN      = 4'hB;
	localparam logic [ADDR_W-1:0] ADDR_INTENSITY = 4'hA;
	localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 4'hC;
	localparam logic [DATA_W-1:0] BLANK_CODE     = 8'h0F;
	localparam logic [DATA_W-1:0] TEST_OFF       = 8'h00;
	localparam logic [DATA_W-1:0] SHUTDOWN_OFF   = 8'h01;

	localparam int DECODE_RST_W = 8;
	localparam logic [DECODE_RST_W-1:0] DECODE_RST = 8'h7F;

	typedef enum logic [1:0] {
		CMD_SHOW  = 2'd0,
		CMD_BLANK = 2'd1,
		CMD_INIT  = 2'd2,
		CMD_NOP   = 2'd3
	} ddf_cmd_t;

	typedef enum logic [1:0] {
		REG_DECODE    = 2'd0,
		REG_SCAN      = 2'd1,
		REG_INTENSITY = 2'd2,
		REG_NONE      = 2'd3
	} ddf_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SEND
	} ddf_state_t;

	typedef struct packed {
		logic clear;
		logic dabble;
		logic unload;
	} ddf_cell_ctl_t;

endpackage

@@ design/ddf_bcd_cell.sv @@
// ----------------------------------------------------------------------------
// ddf_bcd_cell
// One decimal digit of the shift-and-add-three chain; also shifts digits down.
// ----------------------------------------------------------------------------
module ddf_bcd_cell (
	input  logic                          clk,
	input  ddf_pkg::ddf_cell_ctl_t        ctl,
	input  logic                          shift_in,
	input  logic [ddf_pkg::DIGIT_W-1:0]   upper_digit,
	output logic                          carry_out,
	output logic [ddf_pkg::DIGIT_W-1:0]   digit
);
	import ddf_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	assign adj       = (digit_q >= DIGIT_W'(5)) ? digit_q + DIGIT_W'(3) : digit_q;
	assign carry_out = adj[DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], shift_in};
		end else if (ctl.unload) begin
			digit_q <= upper_digit;
		end
	end

endmodule

@@ design/ddf_digit_chain.sv @@
// ----------------------------------------------------------------------------
// ddf_digit_chain
// Value shift register feeding a row of BCD cells, lowest digit first.
// ----------------------------------------------------------------------------
module ddf_digit_chain (
	input  logic                          clk,
	input  ddf_pkg::ddf_cell_ctl_t        ctl,
	input  logic [ddf_pkg::VALUE_W-1:0]   value,
	output logic [ddf_pkg::DIGIT_W-1:0]   low_digit
);
	import ddf_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic               carry   [MAX_DIGITS];
	logic [DIGIT_W-1:0] digits  [MAX_DIGITS];

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			value_q <= value;
		end else if (ctl.dabble) begin
			value_q <= {value_q[VALUE_W-2:0], 1'b0};
		end
	end

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		logic               cell_in;
		logic [DIGIT_W-1:0] cell_upper;

		if (i == 0) begin : g_first
			assign cell_in = value_q[VALUE_W-1];
		end else begin : g_next
			assign cell_in = carry[i-1];
		end

		if (i == MAX_DIGITS-1) begin : g_top
			assign cell_upper = '0;
		end else begin : g_mid
			assign cell_upper = digits[i+1];
		end

		ddf_bcd_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.shift_in    (cell_in),
			.upper_digit (cell_upper),
			.carry_out   (carry[i]),
			.digit       (digits[i])
		);
	end

	assign low_digit = digits[0];

endmodule

@@ design/decimal_digit_display_framer.sv @@
// ----------------------------------------------------------------------------
// decimal_digit_display_framer
// Turns display commands into register-write frames for a digit display.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  s_*     | tvalid tready tdata[39:0] tuser[1:0]      | command in
//  m_*     | tvalid tready tdata[15:0] tuser[1:0] tlast| frame out
//  cfg_*   | valid ready index[1:0] data[7:0]          | register write
//
//  Show number: the command is accepted, then converted through the BCD cell
//  chain (one value bit a cycle), then one frame a cycle unless the output stalls.
//  Blank, init, empty and error commands skip conversion and go straight to the frames.
//  A new command is taken once the last frame sits in the output register.
//  Reset clears the control state and sets the registers to 127, 6 and 10.
//  Output stalls hold the sequencer; configuration is always taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_digit_display_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[30:0], digit_count[34:31], zero fill
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // reg_address[3:0], reg_data[11:4], zero fill
	output logic [1:0]  m_tuser,   // frame_valid[0], status[1]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import ddf_pkg::*;

	ddf_state_t          state_q, state_d;
	ddf_cmd_t            cmd_q, s_cmd;
	logic                special_q, err_q;
	logic [COUNT_W-1:0]  total_q, idx_q;
	logic [BITCNT_W-1:0] bit_cnt_q;
	logic [7:0]          decode_q;
	logic [2:0]          scan_q;
	logic [3:0]          intensity_q;

	logic [VALUE_W-1:0]  s_value;
	logic [COUNT_W-1:0]  s_count;
	logic                s_special, s_err;
	ddf_cell_ctl_t       cell_ctl;
	logic [DIGIT_W-1:0]  low_digit;

	logic                out_free, emit, last_c;
	logic                f_valid, f_status;
	logic [ADDR_W-1:0]   f_addr;
	logic [DATA_W-1:0]   f_data;

	logic                m_tvalid_q, m_tlast_q;
	logic [ADDR_W-1:0]   m_addr_q;
	logic [DATA_W-1:0]   m_data_q;
	logic [1:0]          m_tuser_q;

	assign s_value   = s_tdata[VALUE_W-1:0];
	assign s_count   = s_tdata[VALUE_W+COUNT_W-1:VALUE_W];
	assign s_cmd     = ddf_cmd_t'(s_tuser);
	assign s_err     = (s_count > COUNT_W'(MAX_DIGITS));
	assign s_special = s_err || (s_count == '0);
	assign out_free  = !m_tvalid_q || m_tready;
	assign last_c    = (idx_q + COUNT_W'(1)) == total_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_q    <= DECODE_RST;
			scan_q      <= 3'd6;
			intensity_q <= 4'd10;
		end else if (cfg_valid) begin
			unique case (ddf_reg_t'(cfg_index))
				REG_DECODE:    decode_q    <= cfg_data;
				REG_SCAN:      scan_q      <= cfg_data[2:0];
				REG_INTENSITY: intensity_q <= cfg_data[3:0];
				REG_NONE:      ;
				default:       ;
			endcase
		end
	end

	ddf_digit_chain u_chain (
		.clk       (clk),
		.ctl       (cell_ctl),
		.value     (s_value),
		.low_digit (low_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cell_ctl = '0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cell_ctl.clear = 1'b1;
					if (s_cmd == CMD_SHOW && !s_special) begin
						state_d = ST_CONV;
					end else if (s_cmd != CMD_NOP) begin
						state_d = ST_SEND;
					end
				end
			end
			ST_CONV: begin
				cell_ctl.dabble = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (out_free) begin
					emit            = 1'b1;
					cell_ctl.unload = (cmd_q == CMD_SHOW) && !special_q;
					if (last_c) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= CMD_NOP;
			special_q <= 1'b0;
			err_q     <= 1'b0;
			total_q   <= '0;
			idx_q     <= '0;
			bit_cnt_q <= '0;
		end else if (s_tvalid && s_tready) begin
			cmd_q     <= s_cmd;
			special_q <= s_special;
			err_q     <= s_err;
			idx_q     <= '0;
			bit_cnt_q <= BITCNT_W'(VALUE_W-1);
			case (s_cmd)
				CMD_SHOW:  total_q <= s_special ? COUNT_W'(1) : s_count;
				CMD_BLANK: total_q <= COUNT_W'(MAX_DIGITS);
				default:   total_q <= COUNT_W'(INIT_FRAMES);
			endcase
		end else begin
			if (state_q == ST_CONV) begin
				bit_cnt_q <= bit_cnt_q - BITCNT_W'(1);
			end
			if (emit) begin
				idx_q <= idx_q + COUNT_W'(1);
			end
		end
	end

	// frame contents
	always_comb begin
		f_valid  = 1'b1;
		f_status = 1'b0;
		f_addr   = ADDR_W'(idx_q) + ADDR_W'(1);
		f_data   = '0;
		case (cmd_q)
			CMD_SHOW: begin
				if (special_q) begin
					f_valid  = 1'b0;
					f_status = err_q;
					f_addr   = '0;
				end else begin
					f_data = DATA_W'(low_digit);
				end
			end
			CMD_BLANK: f_data = BLANK_CODE;
			default: begin
				case (idx_q)
					COUNT_W'(0): begin
						f_addr = ADDR_DECODE;
						f_data = decode_q;
					end
					COUNT_W'(1): begin
						f_addr = ADDR_TEST;
						f_data = TEST_OFF;
					end
					COUNT_W'(2): begin
						f_addr = ADDR_SCAN;
						f_data = DATA_W'(scan_q);
					end
					COUNT_W'(3): begin
						f_addr = ADDR_INTENSITY;
						f_data = DATA_W'(intensity_q);
					end
					default: begin
						f_addr = ADDR_SHUTDOWN;
						f_data = SHUTDOWN_OFF;
					end
				endcase
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_addr_q  <= f_addr;
			m_data_q  <= f_data;
			m_tlast_q <= last_c;
			m_tuser_q <= {f_status, f_valid};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, m_data_q, m_addr_q};
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`DDF_ASSERT(a_send_in_range, (state_q == ST_SEND) |-> (idx_q < total_q && total_q != '0), "idx")
	`DDF_ASSERT(a_empty_is_last, (m_tvalid && !m_tuser[0]) |-> m_tlast, "frameless result not last")
	`DDF_ASSERT(a_err_no_frame, (m_tvalid && m_tuser[1]) |-> !m_tuser[0], "error result with frame")
	`DDF_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !m_tvalid, "output valid after reset")

endmodule
